// ===== src/bda_pkg.sv =====
package bda_pkg;

	localparam int VALUE_W        = 32;
	localparam int WORD_DIGITS    = 10;
	localparam int MAX_DIGITS_DEF = 10;
	localparam int BITS_PER_STEP  = 4;
	localparam int STEPS          = VALUE_W / BITS_PER_STEP;
	localparam int QUEUE_DEPTH    = 2;
	localparam int CHAR_W         = 6;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	// Decimal positions actually held: clamped to one through ten.
	function automatic int held_pos(input int max_digits);
		int n;
		n = max_digits;
		if (n < 1) n = 1;
		if (n > WORD_DIGITS) n = WORD_DIGITS;
		return n;
	endfunction

	function automatic int idx_width(input int max_digits);
		int n;
		n = held_pos(max_digits);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

// ===== src/bda_front.sv =====
module bda_front #(
	parameter int MAX_DIGITS = bda_pkg::MAX_DIGITS_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             in_valid,
	output logic                                             in_stall,
	input  logic [bda_pkg::VALUE_W-1:0]                      value,
	output logic                                             push_valid,
	input  logic                                             push_ready,
	output logic [4*bda_pkg::held_pos(MAX_DIGITS)-1:0]       push_digits,
	output logic [bda_pkg::idx_width(MAX_DIGITS)-1:0]        push_top
);
	import bda_pkg::*;

	localparam int POS    = held_pos(MAX_DIGITS);
	localparam int IDX_W  = idx_width(MAX_DIGITS);
	localparam int BCD_W  = 4 * POS;
	localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [VALUE_W-1:0] bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [VALUE_W-1:0] bin_nx;
	logic [BCD_W-1:0]   bcd_nx;
	logic [IDX_W-1:0]   top;
	logic               accept;

	assign in_stall = busy_q | (done_q & ~push_ready);
	assign accept   = in_valid & ~in_stall;

	// Shift-and-add-three over a few input bits per cycle. Digits above the
	// held positions fall off the top, which keeps the value modulo 10^POS.
	always_comb begin
		bcd_nx = bcd_q;
		bin_nx = bin_q;
		for (int s = 0; s < BITS_PER_STEP; s++) begin
			for (int d = 0; d < POS; d++) begin
				if (bcd_nx[4*d +: 4] >= 4'd5) begin
					bcd_nx[4*d +: 4] = bcd_nx[4*d +: 4] + 4'd3;
				end
			end
			if (BCD_W > 1) begin
				bcd_nx = {bcd_nx[BCD_W-2:0], bin_nx[VALUE_W-1]};
			end
			bin_nx = {bin_nx[VALUE_W-2:0], 1'b0};
		end
	end

	// Highest nonzero digit; the units digit is always emitted.
	always_comb begin
		top = '0;
		for (int k = 0; k < POS; k++) begin
			if (bcd_q[4*k +: 4] != 4'd0) begin
				top = IDX_W'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (done_q && push_ready) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= bin_nx;
			bcd_q <= bcd_nx;
		end
	end

	assign push_valid  = done_q;
	assign push_digits = bcd_q;
	assign push_top    = top;

endmodule

// ===== src/bda_queue.sv =====
module bda_queue #(
	parameter int ENTRY_W = 44
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  logic [ENTRY_W-1:0] push_data,
	output logic               pop_valid,
	input  logic               pop,
	output logic [ENTRY_W-1:0] pop_data
);
	import bda_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [ENTRY_W-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop & pop_valid;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== src/bda_back.sv =====
module bda_back #(
	parameter int MAX_DIGITS = bda_pkg::MAX_DIGITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       q_valid,
	output logic                                       q_pop,
	input  logic [4*bda_pkg::held_pos(MAX_DIGITS)-1:0] q_digits,
	input  logic [bda_pkg::idx_width(MAX_DIGITS)-1:0]  q_top,
	output logic                                       out_valid,
	input  logic                                       out_stall,
	output logic [bda_pkg::CHAR_W-1:0]                 digit_char,
	output logic                                       last
);
	import bda_pkg::*;

	localparam int POS   = held_pos(MAX_DIGITS);
	localparam int IDX_W = idx_width(MAX_DIGITS);

	logic               active_q;
	logic [IDX_W-1:0]   idx_q;
	logic [4*POS-1:0]   digits_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;
	logic               adv;
	logic               emit;
	logic [IDX_W-1:0]   cur_idx;
	logic [3:0]         cur_digit;

	// The output register frees up when empty or when its request is taken.
	assign adv   = ~out_valid_q | ~out_stall;
	assign q_pop = adv & ~active_q & q_valid;
	assign emit  = adv & (active_q | q_valid);

	always_comb begin
		if (active_q) begin
			cur_idx   = idx_q;
			cur_digit = digits_q[4*idx_q +: 4];
		end else begin
			cur_idx   = q_top;
			cur_digit = q_digits[4*q_top +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (adv) begin
			out_valid_q <= emit;
			if (emit) begin
				active_q <= (cur_idx != '0);
				idx_q    <= cur_idx - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			digits_q <= q_digits;
		end
		if (emit) begin
			char_q <= ASCII_ZERO + {{(CHAR_W-4){1'b0}}, cur_digit};
			last_q <= (cur_idx == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = char_q;
	assign last       = last_q;

endmodule

// ===== src/binary_to_decimal_ascii.sv =====
// A value accepted at the input passes through the converter, the queue and the output
// register before its first character appears. The shift-and-add-three converter takes 4
// bits a cycle and takes a new value only once the last is converted and pushed; characters
// leave one per cycle from the output register while out_stall is low, so long values hold
// back the input, and a two-entry queue lets conversion run ahead of a slow or stalled output.
// Reset is asynchronous and active low; it clears only control state.
module binary_to_decimal_ascii #(
	parameter int MAX_DIGITS = bda_pkg::MAX_DIGITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [bda_pkg::VALUE_W-1:0]  value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [bda_pkg::CHAR_W-1:0]   digit_char,
	output logic                         last
);
	import bda_pkg::*;

	localparam int POS     = held_pos(MAX_DIGITS);
	localparam int IDX_W   = idx_width(MAX_DIGITS);
	localparam int ENTRY_W = 4 * POS + IDX_W;

	logic               push_valid;
	logic               push_ready;
	logic [4*POS-1:0]   push_digits;
	logic [IDX_W-1:0]   push_top;
	logic               q_valid;
	logic               q_pop;
	logic [ENTRY_W-1:0] q_data;

	bda_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.value       (value),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_digits (push_digits),
		.push_top    (push_top)
	);

	bda_queue #(.ENTRY_W(ENTRY_W)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_digits, push_top}),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_data   (q_data)
	);

	bda_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_digits   (q_data[ENTRY_W-1:IDX_W]),
		.q_top      (q_data[IDX_W-1:0]),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digit_char (digit_char),
		.last       (last)
	);

endmodule
